FILE: rtl/assert_macros.svh
// assertion helpers for the autokey cipher block
// no dependencies; taken in by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define XAKF_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define XAKF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define XAKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/xakf_pkg.sv
// shared types and constants of the xor autokey framed cipher
// no dependencies; used by the item and cfg interfaces and all modules
package xakf_pkg;

    localparam int LEN_WIDTH_DEFAULT = 16;
    localparam int MSG_LEN_W         = 16;
    localparam int HDR_BYTES         = 4;
    localparam int HL_W              = 8 * HDR_BYTES;
    localparam int MAX_RESULTS       = 5;
    localparam int RES_CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam int QDEPTH            = 8;
    localparam int QPTR_W            = $clog2(QDEPTH);
    localparam int QCNT_W            = $clog2(QDEPTH + 1);
    localparam int CFG_INDEX_W       = 4;
    localparam int CFG_DATA_W        = 8;

    localparam logic [7:0] KEY_INIT = 8'd171;

    localparam logic [CFG_INDEX_W-1:0] REG_ENCRYPT_MODE   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_ENABLED = CFG_INDEX_W'(1);

    typedef struct packed {
        logic encrypt_mode;
        logic header_enabled;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       truncated;
    } out_item_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]              count;
        out_item_t [MAX_RESULTS-1:0]       items;
    } push_t;

endpackage

FILE: rtl/xakf_if.sv
// handshake channels of the cipher block: input bytes, results, register writes
// depends on xakf_pkg for field widths
interface xakf_item_if import xakf_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [7:0]           data_byte;
    logic                 start_req;
    logic [MSG_LEN_W-1:0] message_length;

    modport source (output valid, data_byte, start_req, message_length, input ready);
    modport sink   (input valid, data_byte, start_req, message_length, output ready);
endinterface

interface xakf_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       truncated;

    modport source (output valid, out_byte, last, truncated, input ready);
    modport sink   (input valid, out_byte, last, truncated, output ready);
endinterface

interface xakf_cfg_if import xakf_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: rtl/xakf_cfg_regs.sv
// configuration registers: mode and header enable
// depends on xakf_pkg and xakf_cfg_if
module xakf_cfg_regs
    import xakf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    xakf_cfg_if.sink   cfg,
    output cfg_t       regs
);

    logic encrypt_mode_reg;
    logic header_enabled_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encrypt_mode_reg   <= 1'b0;
            header_enabled_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_ENCRYPT_MODE:   encrypt_mode_reg   <= cfg.wdata[0];
                REG_HEADER_ENABLED: header_enabled_reg <= cfg.wdata[0];
                default:            ;
            endcase
        end
    end

    assign regs.encrypt_mode   = encrypt_mode_reg;
    assign regs.header_enabled = header_enabled_reg;

endmodule

FILE: rtl/xakf_core.sv
// input register, cipher and framing logic, per-message state
// depends on xakf_pkg, xakf_item_if and assert_macros.svh
`include "assert_macros.svh"
module xakf_core
    import xakf_pkg::*;
#(
    parameter int LEN_WIDTH = LEN_WIDTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    xakf_item_if.sink         item,
    input  cfg_t              cfg,
    input  logic [QCNT_W-1:0] free,
    output push_t             push
);

    // input register
    logic                 iv_reg;
    logic [7:0]           byte_reg;
    logic                 start_reg;
    logic [MSG_LEN_W-1:0] mlen_reg;

    // message state
    logic [7:0]           key_reg, key_next;
    logic [LEN_WIDTH-1:0] pos_reg, pos_next;
    logic [LEN_WIDTH-1:0] total_reg, total_next;
    logic [LEN_WIDTH-1:0] rem_reg, rem_next;
    logic                 fb_reg, fb_next;
    logic [7:0]           hdr_reg [HDR_BYTES-1];
    logic                 hdr_we;
    logic [1:0]           hdr_idx;

    logic                        fire;
    logic [RES_CNT_W-1:0]        n;
    out_item_t [MAX_RESULTS-1:0] items;

    always_comb
    begin
        logic [7:0]           key0;
        logic [LEN_WIDTH-1:0] pos0;
        logic [LEN_WIDTH-1:0] tot0;
        logic [LEN_WIDTH-1:0] rem0;
        logic                 fb0;
        logic [HL_W-1:0]      len32;
        logic [HL_W-1:0]      room;
        logic [HL_W-1:0]      hl;
        logic [7:0]           c;
        logic                 burst;

        key0  = start_reg ? KEY_INIT : key_reg;
        pos0  = start_reg ? '0 : pos_reg;
        tot0  = start_reg ? LEN_WIDTH'(mlen_reg) : total_reg;
        rem0  = start_reg ? '0 : rem_reg;
        fb0   = start_reg ? 1'b0 : fb_reg;
        len32 = HL_W'(tot0);
        room  = HL_W'(tot0 - LEN_WIDTH'(HDR_BYTES));
        hl    = {hdr_reg[0], hdr_reg[1], hdr_reg[2], byte_reg};
        c     = byte_reg ^ key0;
        burst = start_reg && cfg.encrypt_mode && cfg.header_enabled;

        key_next   = key0;
        pos_next   = pos0;
        total_next = tot0;
        rem_next   = rem0;
        fb_next    = fb0;
        hdr_we     = 1'b0;
        hdr_idx    = pos0[1:0];
        n          = '0;
        items      = '0;

        // length header ahead of the ciphertext
        if (burst)
        begin
            items[0].out_byte = len32[31:24];
            items[1].out_byte = len32[23:16];
            items[2].out_byte = len32[15:8];
            items[3].out_byte = len32[7:0];
            items[3].last     = (tot0 == '0);
            n = RES_CNT_W'(HDR_BYTES);
        end

        if (pos0 < tot0)
        begin
            pos_next = pos0 + LEN_WIDTH'(1);
            if (cfg.encrypt_mode)
            begin
                key_next = c;
                if (burst)
                begin
                    items[4].out_byte = c;
                    items[4].last     = (pos0 == tot0 - LEN_WIDTH'(1));
                end
                else
                begin
                    items[0].out_byte = c;
                    items[0].last     = (pos0 == tot0 - LEN_WIDTH'(1));
                end
                n = n + RES_CNT_W'(1);
            end
            else if (tot0 > LEN_WIDTH'(HDR_BYTES))
            begin
                if (pos0 < LEN_WIDTH'(HDR_BYTES))
                begin
                    hdr_we = (pos0 < LEN_WIDTH'(HDR_BYTES - 1));
                    if (pos0 == LEN_WIDTH'(HDR_BYTES - 1))
                    begin
                        if (hl > room)
                        begin
                            // header overruns the frame: decode it as data
                            fb_next = 1'b1;
                            items[0] = '{hdr_reg[0] ^ key0, 1'b0, 1'b1};
                            items[1] = '{hdr_reg[1] ^ hdr_reg[0], 1'b0, 1'b1};
                            items[2] = '{hdr_reg[2] ^ hdr_reg[1], 1'b0, 1'b1};
                            items[3] = '{byte_reg ^ hdr_reg[2], 1'b0, 1'b1};
                            key_next = byte_reg;
                            n = RES_CNT_W'(HDR_BYTES);
                        end
                        else
                        begin
                            rem_next = hl[LEN_WIDTH-1:0];
                        end
                    end
                end
                else if (fb0)
                begin
                    items[0] = '{c, (pos0 == tot0 - LEN_WIDTH'(1)), 1'b1};
                    key_next = byte_reg;
                    n = RES_CNT_W'(1);
                end
                else if (rem0 != '0)
                begin
                    rem_next = rem0 - LEN_WIDTH'(1);
                    items[0] = '{c, (rem0 == LEN_WIDTH'(1)), 1'b0};
                    key_next = byte_reg;
                    n = RES_CNT_W'(1);
                end
            end
        end

        fire = iv_reg && (QCNT_W'(n) <= free);
    end

    assign item.ready  = !iv_reg || fire;
    assign push.count  = fire ? n : '0;
    assign push.items  = items;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg    <= 1'b0;
            key_reg   <= KEY_INIT;
            pos_reg   <= '0;
            total_reg <= '0;
            rem_reg   <= '0;
            fb_reg    <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                iv_reg <= item.valid;
            end
            if (fire)
            begin
                key_reg   <= key_next;
                pos_reg   <= pos_next;
                total_reg <= total_next;
                rem_reg   <= rem_next;
                fb_reg    <= fb_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            byte_reg  <= item.data_byte;
            start_reg <= item.start_req;
            mlen_reg  <= item.message_length;
        end
        if (fire && hdr_we)
        begin
            hdr_reg[hdr_idx] <= byte_reg;
        end
    end

    `XAKF_ASSERT(a_pos_in_frame, clk, rst_n, pos_reg <= total_reg, "byte position past frame end")
    `XAKF_ASSERT_IMPL(a_five_at_start, clk, rst_n, push.count == RES_CNT_W'(MAX_RESULTS), start_reg && cfg.encrypt_mode, "five results outside an encrypt start")
    `XAKF_ASSERT_NEXT(a_stall_holds, clk, rst_n, iv_reg && !fire, iv_reg, "pending byte lost while waiting for queue space")

endmodule

FILE: rtl/xakf_out_queue.sv
// result queue: takes up to five results a cycle, hands out one per transaction
// depends on xakf_pkg, xakf_result_if and assert_macros.svh
`include "assert_macros.svh"
module xakf_out_queue
    import xakf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  push_t             push,
    output logic [QCNT_W-1:0] free,
    xakf_result_if.source     result
);

    out_item_t          q_reg [QDEPTH];
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               pop;

    assign pop        = result.valid && result.ready;
    assign free       = QCNT_W'(QDEPTH) - count_reg + QCNT_W'(pop);
    assign count_next = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);

    assign result.valid     = (count_reg != '0);
    assign result.out_byte  = q_reg[rd_ptr_reg].out_byte;
    assign result.last      = q_reg[rd_ptr_reg].last;
    assign result.truncated = q_reg[rd_ptr_reg].truncated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push.count);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (RES_CNT_W'(k) < push.count)
            begin
                q_reg[wr_ptr_reg + QPTR_W'(k)] <= push.items[k];
            end
        end
    end

    `XAKF_ASSERT(a_count_max, clk, rst_n, count_reg <= QCNT_W'(QDEPTH), "result queue count out of range")
    `XAKF_ASSERT_IMPL(a_no_overflow, clk, rst_n, push.count != '0, QCNT_W'(push.count) <= free, "results pushed into a full queue")

endmodule

FILE: rtl/xor_autokey_framed_cipher_top.sv
// top level of the xor autokey framed cipher
// depends on xakf_pkg, the channel interfaces, xakf_cfg_regs, xakf_core, xakf_out_queue
//
// item channel: one byte per transaction with start_req marking the first byte
// of a message and message_length sampled on that byte. result channel: one
// output byte per transaction with last and truncated flags. cfg channel:
// register writes (0 encrypt_mode, 1 header_enabled), always ready; write only
// while the block is idle.
// an accepted byte waits in the input register until the result queue has room
// for its results. throughput: one byte per cycle while the queue has room, set
// by the single-pass cipher stage between the input register and the result
// queue. a byte that yields several results (length header on an encrypt start,
// header fallback on decrypt) pushes them into the queue at once; they drain one
// per cycle through the result port while the receiver is ready, and a burst
// stalls the input only when the 8-entry queue lacks room for it.
// reset clears the registers, the message state and the queue; no sweep is
// needed. when the receiver stalls, results wait in the queue and the input
// keeps flowing until the queue fills.
module xor_autokey_framed_cipher_top
    import xakf_pkg::*;
#(
    parameter int LEN_WIDTH = LEN_WIDTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    xakf_item_if.sink     item,
    xakf_result_if.source result,
    xakf_cfg_if.sink      cfg
);

    cfg_t              regs;
    push_t             push;
    logic [QCNT_W-1:0] free;

    xakf_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    xakf_core #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cfg   (regs),
        .free  (free),
        .push  (push)
    );

    xakf_out_queue u_out_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .free   (free),
        .result (result)
    );

endmodule
